FILE: src/esc_pkg.sv
// Package for the epoch-seconds to calendar converter.
// Holds widths, time and calendar constants and the month length table.
// No dependencies.
`timescale 1ns / 1ps

package esc_pkg;

  localparam int SecondsWidth = 32;
  localparam int DivWidth     = 18;   // remainder register, holds up to 2 * 86400
  localparam int DaysWidth    = 16;   // day count since epoch at 32-bit seconds
  localparam int CntWidth     = 6;

  localparam int SecondsPerDay  = 86400;
  localparam int SecondsPerHour = 3600;
  localparam int SecondsPerMin  = 60;
  localparam int DaysPerWeek    = 7;

  localparam int SodWidth  = 17;      // second of day
  localparam int SohWidth  = 12;      // second of hour

  localparam logic [8:0] DaysCommonYear = 9'd365;
  localparam logic [8:0] DaysLeapYear   = 9'd366;

  // Year is kept as an offset from 1900; the walk starts at 1970.
  localparam logic [7:0] StartYear      = 8'd70;
  localparam logic [6:0] StartYearMod100 = 7'd70;
  localparam logic [8:0] StartYearMod400 = 9'd370;

  localparam logic [3:0] MonthJan = 4'd0;
  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthDec = 4'd11;

  typedef logic [SecondsWidth-1:0] seconds_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: src/epoch_seconds_to_calendar_unit.sv
// Epoch-seconds to calendar date and time converter, top level.
// Uses esc_pkg for constants and the month length table.
// One shared compare/subtract unit under a small sequencer does all the work.
//
// Usage:
//   Drive epoch_seconds_i and pulse start while busy is low; the word is taken
//   at that clock edge and busy rises on the next cycle.
//   When the conversion ends, done_o is high for exactly one cycle with all
//   result fields valid in that cycle; busy falls in the same cycle, so a new
//   start can be given then. The receiver cannot stall the result; fields
//   are only valid while done_o is high.
// Sequence, from the accepting edge to done_o:
//   restoring division for day, hour, minute and weekday, then a year walk
//   from 1970 on that takes off one year's length per step until the days
//   left are fewer than that year's length, then a month walk that does the
//   same per month, up to December at most. The year walk through the shared
//   subtractor is the longest part for late dates. The next word is taken at
//   the earliest at the edge that ends the done_o cycle.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and clears
// done_o; any conversion in flight is dropped.
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  esc_pkg::seconds_t     epoch_seconds_i,
  output logic                  done_o,
  output logic [5:0]            second_of_minute_o,
  output logic [5:0]            minute_of_hour_o,
  output logic [4:0]            hour_of_day_o,
  output logic [2:0]            day_of_week_o,
  output logic [7:0]            years_since_1900_o,
  output logic [3:0]            month_index_o,
  output logic [4:0]            day_of_month_o
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StDivDay,
    StDivHour,
    StDivMin,
    StDivWday,
    StYear,
    StMonth
  } state_e;

  state_e                state_q;
  logic [CntWidth-1:0]   cnt_q;
  logic [SecondsWidth-1:0] dvd_q;
  logic [DivWidth-1:0]   acc_q;
  logic [DaysWidth-1:0]  days_q;
  logic [7:0]            year_q;
  logic [6:0]            mod100_q;
  logic [8:0]            mod400_q;
  logic [3:0]            month_q;
  logic                  leap_q;
  logic                  done_q;
  logic [5:0]            sec_q;
  logic [5:0]            min_q;
  logic [4:0]            hour_q;
  logic [2:0]            wday_q;

  // Shared compare/subtract unit
  logic [DivWidth-1:0]   op_a;
  logic [DivWidth-1:0]   op_b;
  logic [DivWidth:0]     diff;
  logic                  ge;

  logic [DivWidth-1:0]   acc_shift;
  logic [DivWidth-1:0]   acc_next;
  logic [SecondsWidth-1:0] dvd_next;
  logic                  leap_cur;
  logic [8:0]            year_len;
  logic [4:0]            mon_len;
  logic [2:0]            wday_adj;

  assign acc_shift = {acc_q[DivWidth-2:0], dvd_q[SecondsWidth-1]};
  assign leap_cur  = (year_q[1:0] == 2'd0) && ((mod100_q != 7'd0) || (mod400_q == 9'd0));
  assign year_len  = leap_cur ? DaysLeapYear : DaysCommonYear;
  assign mon_len   = month_len(month_q, leap_q);

  always_comb begin
    op_a = acc_shift;
    op_b = DivWidth'(SecondsPerDay);
    unique case (state_q)
      StDivDay:  op_b = DivWidth'(SecondsPerDay);
      StDivHour: op_b = DivWidth'(SecondsPerHour);
      StDivMin:  op_b = DivWidth'(SecondsPerMin);
      StDivWday: op_b = DivWidth'(DaysPerWeek);
      StYear: begin
        op_a = DivWidth'(days_q);
        op_b = DivWidth'(year_len);
      end
      StMonth: begin
        op_a = DivWidth'(days_q);
        op_b = DivWidth'(mon_len);
      end
      default: begin
        op_a = acc_shift;
        op_b = DivWidth'(SecondsPerDay);
      end
    endcase
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign ge   = ~diff[DivWidth];

  // Restoring division step: quotient bits shift into the dividend's low end
  assign acc_next = ge ? diff[DivWidth-1:0] : acc_shift;
  assign dvd_next = {dvd_q[SecondsWidth-2:0], ge};

  // (days + 4) mod 7 from days mod 7
  assign wday_adj = (acc_next[2:0] >= 3'd3) ? (acc_next[2:0] - 3'd3) : (acc_next[2:0] + 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      dvd_q    <= '0;
      acc_q    <= '0;
      days_q   <= '0;
      year_q   <= '0;
      mod100_q <= '0;
      mod400_q <= '0;
      month_q  <= '0;
      leap_q   <= 1'b0;
      sec_q    <= '0;
      min_q    <= '0;
      hour_q   <= '0;
      wday_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            dvd_q   <= epoch_seconds_i;
            acc_q   <= '0;
            cnt_q   <= CntWidth'(SecondsWidth);
            state_q <= StDivDay;
          end
        end
        StDivDay, StDivHour, StDivMin, StDivWday: begin
          dvd_q <= dvd_next;
          acc_q <= acc_next;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CntWidth'(1)) begin
            acc_q <= '0;
            unique case (state_q)
              StDivDay: begin
                days_q  <= dvd_next[DaysWidth-1:0];
                dvd_q   <= {acc_next[SodWidth-1:0], {(SecondsWidth-SodWidth){1'b0}}};
                cnt_q   <= CntWidth'(SodWidth);
                state_q <= StDivHour;
              end
              StDivHour: begin
                hour_q  <= dvd_next[4:0];
                dvd_q   <= {acc_next[SohWidth-1:0], {(SecondsWidth-SohWidth){1'b0}}};
                cnt_q   <= CntWidth'(SohWidth);
                state_q <= StDivMin;
              end
              StDivMin: begin
                min_q   <= dvd_next[5:0];
                sec_q   <= acc_next[5:0];
                dvd_q   <= {days_q, {(SecondsWidth-DaysWidth){1'b0}}};
                cnt_q   <= CntWidth'(DaysWidth);
                state_q <= StDivWday;
              end
              default: begin
                wday_q   <= wday_adj;
                year_q   <= StartYear;
                mod100_q <= StartYearMod100;
                mod400_q <= StartYearMod400;
                state_q  <= StYear;
              end
            endcase
          end
        end
        StYear: begin
          if (!ge) begin
            leap_q  <= leap_cur;
            month_q <= MonthJan;
            state_q <= StMonth;
          end else begin
            days_q   <= diff[DaysWidth-1:0];
            year_q   <= year_q + 8'd1;
            mod100_q <= (mod100_q == 7'd99)  ? 7'd0 : mod100_q + 7'd1;
            mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          end
        end
        StMonth: begin
          if (!ge || (month_q == MonthDec)) begin
            done_q  <= 1'b1;
            state_q <= StIdle;
          end else begin
            days_q  <= diff[DaysWidth-1:0];
            month_q <= month_q + 4'd1;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign busy               = (state_q != StIdle);
  assign done_o             = done_q;
  assign second_of_minute_o = sec_q;
  assign minute_of_hour_o   = min_q;
  assign hour_of_day_o      = hour_q;
  assign day_of_week_o      = wday_q;
  assign years_since_1900_o = year_q;
  assign month_index_o      = month_q;
  assign day_of_month_o     = days_q[4:0] + 5'd1;

endmodule
